// ===== hw/rtl/variant_admission_filter_macros.svh =====
// assertion macros shared by the variant admission filter rtl
`ifndef VARIANT_ADMISSION_FILTER_MACROS_SVH
`define VARIANT_ADMISSION_FILTER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define VAF_ASSERT_HOLDS(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define VAF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/vaf_pkg.sv =====
// types and constants shared by the variant admission filter
package vaf_pkg;

  // default number of table slots
  localparam int unsigned TABLE_DEPTH_DEF = 64;

  // saturation value of a slot hit count
  localparam logic [15:0] HITS_MAX = 16'hFFFF;

  // result status codes
  typedef enum logic [2:0] {
    OUT_NOT_READY  = 3'd0,
    OUT_NO_POLICY  = 3'd1,
    OUT_DISABLED   = 3'd2,
    OUT_BELOW_MIN  = 3'd3,
    OUT_ABOVE_MAX  = 3'd4,
    OUT_ADMITTED   = 3'd5,
    OUT_THROTTLED  = 3'd6,
    OUT_TABLE_FULL = 3'd7
  } vaf_outcome_e;

  // one table slot as stored in the slot memory
  typedef struct packed {
    logic [63:0] key;
    logic [15:0] route;
    logic [15:0] hits;
    logic        admitted;
  } vaf_entry_t;

  // lookup result of a table walk
  typedef struct packed {
    logic       found;
    vaf_entry_t entry;
  } vaf_hit_t;

  // one finished result
  typedef struct packed {
    vaf_outcome_e outcome;
    logic         admitted;
    logic [15:0]  hit_count;
  } vaf_result_t;

endpackage

// ===== hw/rtl/vaf_if.sv =====
// request and response channel interfaces of the variant admission filter

// request channel
interface vaf_req_if;
  logic        valid;
  logic        ready;
  logic        key_ready;
  logic        policy_present;
  logic        policy_enabled;
  logic [9:0]  field_count;
  logic [9:0]  min_fields;
  logic [9:0]  max_fields;
  logic [15:0] route_tag;
  logic [63:0] key_tag;
  logic [10:0] route_variant_cap;
  logic [15:0] admit_threshold;

  modport source (
    output valid, key_ready, policy_present, policy_enabled, field_count,
           min_fields, max_fields, route_tag, key_tag, route_variant_cap,
           admit_threshold,
    input  ready
  );

  modport sink (
    input  valid, key_ready, policy_present, policy_enabled, field_count,
           min_fields, max_fields, route_tag, key_tag, route_variant_cap,
           admit_threshold,
    output ready
  );
endinterface

// response channel
interface vaf_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic        admitted;
  logic [15:0] hit_count;

  modport source (
    output valid, outcome, admitted, hit_count,
    input  ready
  );

  modport sink (
    input  valid, outcome, admitted, hit_count,
    output ready
  );
endinterface

// ===== hw/rtl/vaf_ram.sv =====
// generic single-write, single-read memory with registered read data
module vaf_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/vaf_scan.sv =====
// key match and per-route admitted count over one walk of the slot table
module vaf_scan #(
  parameter  int unsigned DEPTH = vaf_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                valid_i,
  input  logic [AW-1:0]       idx_i,
  input  vaf_pkg::vaf_entry_t entry_i,
  input  logic [63:0]         key_i,
  input  logic [15:0]         route_i,
  output vaf_pkg::vaf_hit_t   hit_o,
  output logic [AW-1:0]       hit_idx_o,
  output logic [CW-1:0]       route_cnt_o
);
  import vaf_pkg::*;

  logic          found_q;
  logic [CW-1:0] cnt_q;
  vaf_entry_t    entry_q;
  logic [AW-1:0] idx_q;
  logic          take_hit;
  logic          count_it;

  // first matching key wins; admitted slots of the request route are counted
  assign take_hit = valid_i && !found_q && (entry_i.key == key_i);
  assign count_it = valid_i && entry_i.admitted && (entry_i.route == route_i);

  // match flag and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else if (clear_i) begin
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (take_hit) begin
        found_q <= 1'b1;
      end
      if (count_it) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // captured slot of the match
  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      entry_q <= entry_i;
      idx_q   <= idx_i;
    end
  end

  assign hit_o.found  = found_q;
  assign hit_o.entry  = entry_q;
  assign hit_idx_o    = idx_q;
  assign route_cnt_o  = cnt_q;

endmodule

// ===== hw/rtl/variant_admission_filter.sv =====
// top level of the variant admission filter
//
// Requests come in on req_i and results leave on rsp_o, both valid/ready
// channels; a transaction moves at a clock edge with valid and ready high.
// Each request yields exactly one result. A request that fails a gate (key
// not ready, no policy, disabled, field count out of range) is answered
// without a table walk and leaves the table alone. A request that passes
// walks the filled part of the slot table through one read port of the slot
// memory, one slot per cycle; a hit is updated, a miss takes a free slot.
// Slots are filled from the bottom and never freed, so a fill counter tells
// which slots are valid.
// req_i.ready is high only while no request is in work.
// Reset empties the table at once; no clearing pass is needed.
// The result sits in an output register: when rsp_o stalls, the block still
// takes and works a new request and holds its result until the register
// frees up.
`include "variant_admission_filter_macros.svh"

module variant_admission_filter #(
  parameter int unsigned TABLE_DEPTH = vaf_pkg::TABLE_DEPTH_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  vaf_req_if.sink   req_i,
  vaf_rsp_if.source rsp_o
);
  import vaf_pkg::*;

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > 11) ? CW : 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] ridx_q, ridx_d;
  logic [63:0]   key_q, key_d;
  logic [15:0]   route_q, route_d;
  logic [10:0]   cap_q, cap_d;
  logic [15:0]   thresh_q, thresh_d;
  vaf_result_t   result_q, result_d;
  logic          out_valid_q, out_valid_d;
  vaf_result_t   out_q, out_d;

  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  vaf_entry_t    ram_wdata;
  logic          ram_re;
  vaf_entry_t    ram_rdata;
  vaf_hit_t      scan_hit;
  logic [AW-1:0] scan_idx;
  logic [CW-1:0] route_cnt;
  logic          cnt_ok;
  logic [15:0]   new_hits;
  logic          new_adm;
  logic          table_full;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && (state_q == ST_IDLE);

  // slot memory
  vaf_ram #(
    .WIDTH ($bits(vaf_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // match and route count over the table walk
  vaf_scan #(
    .DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (accept),
    .valid_i     (rd_vld_q && (state_q == ST_SCAN)),
    .idx_i       (ridx_q),
    .entry_i     (ram_rdata),
    .key_i       (key_q),
    .route_i     (route_q),
    .hit_o       (scan_hit),
    .hit_idx_o   (scan_idx),
    .route_cnt_o (route_cnt)
  );

  // admission decision from the walk
  assign cnt_ok     = CMPW'(route_cnt) < CMPW'(cap_q);
  assign new_hits   = (scan_hit.entry.hits == HITS_MAX) ? scan_hit.entry.hits
                                                        : scan_hit.entry.hits + 16'd1;
  assign new_adm    = scan_hit.found
                      ? (scan_hit.entry.admitted || ((new_hits >= thresh_q) && cnt_ok))
                      : ((thresh_q <= 16'd1) && cnt_ok);
  assign table_full = (fill_q == CW'(TABLE_DEPTH));

  assign ram_re    = (state_q == ST_SCAN) && (ptr_q != fill_q);
  assign ram_we    = (state_q == ST_UPDATE) && (scan_hit.found || !table_full);
  assign ram_waddr = scan_hit.found ? scan_idx : fill_q[AW-1:0];

  // write-back slot: updated hit or fresh entry
  always_comb begin
    ram_wdata.key      = key_q;
    ram_wdata.route    = scan_hit.found ? scan_hit.entry.route : route_q;
    ram_wdata.hits     = scan_hit.found ? new_hits : 16'd1;
    ram_wdata.admitted = new_adm;
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    rd_vld_d    = 1'b0;
    ridx_d      = ptr_q[AW-1:0];
    key_d       = key_q;
    route_d     = route_q;
    cap_d       = cap_q;
    thresh_d    = thresh_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d                = req_i.key_tag;
          route_d              = req_i.route_tag;
          cap_d                = req_i.route_variant_cap;
          thresh_d             = req_i.admit_threshold;
          ptr_d                = '0;
          result_d.admitted    = 1'b0;
          result_d.hit_count   = 16'd0;
          result_d.outcome     = OUT_NOT_READY;
          state_d              = ST_RESP;
          // gates in priority order
          if (!req_i.key_ready) begin
            result_d.outcome = OUT_NOT_READY;
          end else if (!req_i.policy_present) begin
            result_d.outcome = OUT_NO_POLICY;
          end else if (!req_i.policy_enabled) begin
            result_d.outcome = OUT_DISABLED;
          end else if (req_i.field_count < req_i.min_fields) begin
            result_d.outcome = OUT_BELOW_MIN;
          end else if (req_i.field_count > req_i.max_fields) begin
            result_d.outcome = OUT_ABOVE_MAX;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // one read per cycle over the filled slots
        if (ram_re) begin
          ptr_d    = ptr_q + CW'(1);
          rd_vld_d = 1'b1;
        end else if (!rd_vld_q) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!scan_hit.found && table_full) begin
          result_d.outcome   = OUT_TABLE_FULL;
          result_d.admitted  = 1'b0;
          result_d.hit_count = 16'd0;
        end else begin
          result_d.outcome   = new_adm ? OUT_ADMITTED : OUT_THROTTLED;
          result_d.admitted  = new_adm;
          result_d.hit_count = scan_hit.found ? new_hits : 16'd1;
          if (!scan_hit.found) begin
            fill_d = fill_q + CW'(1);
          end
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        // hand over once the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = result_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      ridx_q      <= '0;
      key_q       <= '0;
      route_q     <= '0;
      cap_q       <= '0;
      thresh_q    <= '0;
      result_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_vld_d;
      ridx_q      <= ridx_d;
      key_q       <= key_d;
      route_q     <= route_d;
      cap_q       <= cap_d;
      thresh_q    <= thresh_d;
      result_q    <= result_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.outcome   = out_q.outcome;
  assign rsp_o.admitted  = out_q.admitted;
  assign rsp_o.hit_count = out_q.hit_count;

  // checks
  `VAF_ASSERT_HOLDS(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= CW'(TABLE_DEPTH),
    "fill count beyond table depth")
  `VAF_ASSERT_NEXT(a_fill_step, clk_i, rst_ni, 1'b1,
    (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + CW'(1)),
    "fill count moved by more than one")
  `VAF_ASSERT_HOLDS(a_we_update, clk_i, rst_ni, ram_we, state_q == ST_UPDATE,
    "slot write outside update")
  `VAF_ASSERT_HOLDS(a_full_only_full, clk_i, rst_ni,
    rsp_o.valid && (rsp_o.outcome == OUT_TABLE_FULL), table_full,
    "table full reported with free slots")
  `VAF_ASSERT_HOLDS(a_adm_status, clk_i, rst_ni, rsp_o.valid,
    rsp_o.admitted == (rsp_o.outcome == OUT_ADMITTED),
    "admitted flag disagrees with status")

endmodule
